/* hw/rtl/bcg_pkg.sv */
// Battery charge gauge: shared widths, reset values, register codes,
// discharge curve tables and the controller-to-datapath command word.
// No dependencies.
`timescale 1ns / 1ps

package bcg_pkg;

    // Default build parameters
    localparam int SAMPLES_DEF  = 16;
    localparam int ADC_BITS_DEF = 12;

    // Field and state widths
    localparam int SMP_W     = 12;
    localparam int SUM_W     = 20;
    localparam int GAIN_W    = 20;
    localparam int ALPHA_W   = 9;
    localparam int MV_W      = 15;
    localparam int PCT_W     = 7;
    localparam int Q8_W      = 15;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 20;

    // Restoring divider for the curve interpolation: 12 quotient bits, 12-bit divisor
    localparam int QUO_W   = 12;
    localparam int DVS_W   = 12;
    localparam int DSH_W   = DVS_W + QUO_W - 1;
    localparam int STEP_W  = $clog2(QUO_W);

    // Gain product and voltage scaling
    localparam int PROD_W   = QUO_W + GAIN_W;
    localparam int MV_SHIFT = 16;
    localparam logic [MV_W-1:0] MV_SAT = 15'd32767;

    // Smoothing filter
    localparam logic [ALPHA_W-1:0] ALPHA_MAX = 9'd256;
    localparam int                 EPROD_W   = 26;
    localparam logic [Q8_W-1:0]    Q8_MAX    = 15'd25600;
    localparam logic [PCT_W-1:0]   PCT_MAX   = 7'd100;

    // Register reset values
    localparam logic [GAIN_W-1:0]  GAIN_RST  = 20'd292888;
    localparam logic [ALPHA_W-1:0] ALPHA_RST = 9'd64;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 1'd1;

    // Discharge curve, top point first
    localparam int CURVE_N = 19;
    localparam int SEG_N   = CURVE_N - 1;
    localparam int SEG_W   = 5;

    function automatic logic [MV_W-1:0] curve_mv(input logic [SEG_W-1:0] idx);
        logic [MV_W-1:0] v;
        case (idx)
            5'd0:    v = 15'd16800;
            5'd1:    v = 15'd16600;
            5'd2:    v = 15'd16400;
            5'd3:    v = 15'd16200;
            5'd4:    v = 15'd16000;
            5'd5:    v = 15'd15800;
            5'd6:    v = 15'd15600;
            5'd7:    v = 15'd15400;
            5'd8:    v = 15'd15200;
            5'd9:    v = 15'd15000;
            5'd10:   v = 15'd14800;
            5'd11:   v = 15'd14600;
            5'd12:   v = 15'd14400;
            5'd13:   v = 15'd14200;
            5'd14:   v = 15'd14000;
            5'd15:   v = 15'd13800;
            5'd16:   v = 15'd13600;
            5'd17:   v = 15'd13200;
            default: v = 15'd12000;
        endcase
        return v;
    endfunction

    function automatic logic [PCT_W-1:0] curve_pct(input logic [SEG_W-1:0] idx);
        logic [PCT_W-1:0] v;
        case (idx)
            5'd0:    v = 7'd100;
            5'd1:    v = 7'd98;
            5'd2:    v = 7'd95;
            5'd3:    v = 7'd90;
            5'd4:    v = 7'd85;
            5'd5:    v = 7'd78;
            5'd6:    v = 7'd70;
            5'd7:    v = 7'd62;
            5'd8:    v = 7'd54;
            5'd9:    v = 7'd46;
            5'd10:   v = 7'd38;
            5'd11:   v = 7'd30;
            5'd12:   v = 7'd22;
            5'd13:   v = 7'd15;
            5'd14:   v = 7'd10;
            5'd15:   v = 7'd6;
            5'd16:   v = 7'd3;
            5'd17:   v = 7'd1;
            default: v = 7'd0;
        endcase
        return v;
    endfunction

    // Command word, controller to datapath
    typedef struct packed {
        logic acc;       // accept one sample into the sum
        logic grp_end;   // that sample closes the group: latch the group sum
        logic avg;       // group average by reciprocal multiply
        logic div_step;  // one restoring divide step
        logic mul;       // latch average, multiply by gain
        logic mv;        // saturate product to millivolts
        logic seg;       // locate curve segment
        logic num;       // build interpolation numerator, start divide
        logic pct;       // form instant percent
        logic ema_mul;   // smoothing multiply
        logic ema_add;   // smoothing accumulate
        logic out_load;  // load the result register
    } t_cmd;

endpackage

/* hw/rtl/bcg_sample_if.sv */
// Battery charge gauge: input channel carrying one ADC sample word.
// Depends on bcg_pkg.
`timescale 1ns / 1ps

interface bcg_sample_if;
    logic                     valid;
    logic                     ready;
    logic [bcg_pkg::SMP_W-1:0] adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

/* hw/rtl/bcg_result_if.sv */
// Battery charge gauge: output channel carrying one result word.
// Depends on bcg_pkg.
`timescale 1ns / 1ps

interface bcg_result_if;
    logic                     valid;
    logic                     ready;
    logic [bcg_pkg::MV_W-1:0]  pack_millivolts;
    logic [bcg_pkg::PCT_W-1:0] charge_percent;
    logic [bcg_pkg::SMP_W-1:0] raw_average;

    modport source (output valid, output pack_millivolts, output charge_percent,
                    output raw_average, input ready);
    modport sink   (input valid, input pack_millivolts, input charge_percent,
                    input raw_average, output ready);
endinterface

/* hw/rtl/bcg_ctrl.sv */
// Battery charge gauge controller: sample counter, sequencing state machine,
// divide step counter and result valid flag. Depends on bcg_pkg.
`timescale 1ns / 1ps

module bcg_ctrl #(
    parameter int SAMPLES_PER_READING = bcg_pkg::SAMPLES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output bcg_pkg::t_cmd o_cmd
);

    localparam int CNT_W = (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_READING - 1);
    localparam logic [bcg_pkg::STEP_W-1:0] STEP_LAST = bcg_pkg::STEP_W'(bcg_pkg::QUO_W - 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_AVG  = 4'd1;
    localparam logic [3:0] S_MUL  = 4'd2;
    localparam logic [3:0] S_MV   = 4'd3;
    localparam logic [3:0] S_SEG  = 4'd4;
    localparam logic [3:0] S_NUM  = 4'd5;
    localparam logic [3:0] S_DIVP = 4'd6;
    localparam logic [3:0] S_PCT  = 4'd7;
    localparam logic [3:0] S_EMUL = 4'd8;
    localparam logic [3:0] S_EADD = 4'd9;
    localparam logic [3:0] S_FIN  = 4'd10;

    logic [3:0]                   r_state, n_state;
    logic [CNT_W-1:0]             r_cnt, n_cnt;
    logic [bcg_pkg::STEP_W-1:0]   r_step, n_step;
    logic                         r_valid, n_valid;
    logic                         out_free;

    assign out_free    = !r_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_valid;

    // Sequencing
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_step  = r_step;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.acc = 1'b1;
                    if (r_cnt == CNT_LAST) begin
                        o_cmd.grp_end = 1'b1;
                        n_cnt   = '0;
                        n_state = S_AVG;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            S_AVG: begin
                o_cmd.avg = 1'b1;
                n_state   = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_MV;
            end
            S_MV: begin
                o_cmd.mv = 1'b1;
                n_state  = S_SEG;
            end
            S_SEG: begin
                o_cmd.seg = 1'b1;
                n_state   = S_NUM;
            end
            S_NUM: begin
                o_cmd.num = 1'b1;
                n_step    = '0;
                n_state   = S_DIVP;
            end
            S_DIVP: begin
                o_cmd.div_step = 1'b1;
                n_step = r_step + 1'b1;
                if (r_step == STEP_LAST) begin
                    n_state = S_PCT;
                end
            end
            S_PCT: begin
                o_cmd.pct = 1'b1;
                n_state   = S_EMUL;
            end
            S_EMUL: begin
                o_cmd.ema_mul = 1'b1;
                n_state       = S_EADD;
            end
            S_EADD: begin
                o_cmd.ema_add = 1'b1;
                n_state       = S_FIN;
            end
            S_FIN: begin
                // hold until the result register is free
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Result valid: set on load, cleared when taken
    always_comb begin
        if (o_cmd.out_load) begin
            n_valid = 1'b1;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_step  <= n_step;
            r_valid <= n_valid;
        end
    end

endmodule

/* hw/rtl/bcg_dp.sv */
// Battery charge gauge datapath: config registers, sample sum, group average
// multiply, restoring divider, gain multiply, curve lookup, smoothing filter,
// result register. Depends on bcg_pkg.
`timescale 1ns / 1ps

module bcg_dp #(
    parameter int SAMPLES_PER_READING = bcg_pkg::SAMPLES_DEF,
    parameter int ADC_BITS            = bcg_pkg::ADC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bcg_pkg::t_cmd                i_cmd,
    input  logic [bcg_pkg::SMP_W-1:0]    i_adc_sample,
    input  logic                         i_cfg_we,
    input  logic [bcg_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bcg_pkg::CFG_W-1:0]    i_cfg_data,
    output logic [bcg_pkg::MV_W-1:0]     o_pack_millivolts,
    output logic [bcg_pkg::PCT_W-1:0]    o_charge_percent,
    output logic [bcg_pkg::SMP_W-1:0]    o_raw_average
);

    localparam int SMP_EFF = (ADC_BITS < bcg_pkg::SMP_W) ? ADC_BITS : bcg_pkg::SMP_W;
    localparam logic [bcg_pkg::SMP_W-1:0] SMP_MASK = bcg_pkg::SMP_W'((1 << SMP_EFF) - 1);
    localparam int NUM_W = bcg_pkg::MV_W + bcg_pkg::PCT_W + 1;
    localparam int SUM_W = bcg_pkg::SUM_W;
    localparam int DSH_W = bcg_pkg::DSH_W;
    localparam int QUO_W = bcg_pkg::QUO_W;
    localparam int MV_W  = bcg_pkg::MV_W;
    localparam int PCT_W = bcg_pkg::PCT_W;
    localparam int Q8_W  = bcg_pkg::Q8_W;
    localparam int EPROD_W = bcg_pkg::EPROD_W;
    localparam int SEG_W = bcg_pkg::SEG_W;

    // Group average: sum * ceil(2^K / N) >> K is an exact floor for any 20-bit sum
    localparam int AVG_K   = SUM_W + $clog2(SAMPLES_PER_READING);
    localparam int AVG_M_W = SUM_W + 1;
    localparam int AVG_P_W = SUM_W + AVG_M_W;
    localparam logic [AVG_M_W-1:0] AVG_M =
        AVG_M_W'(((64'd1 << AVG_K) + 64'(SAMPLES_PER_READING) - 64'd1)
                 / 64'(SAMPLES_PER_READING));

    // config
    logic [bcg_pkg::GAIN_W-1:0]  r_gain;
    logic [bcg_pkg::ALPHA_W-1:0] r_alpha;
    // accumulation and divider
    logic [SUM_W-1:0]            r_sum;
    logic [SUM_W-1:0]            r_rem;
    logic [DSH_W-1:0]            r_dsh;
    logic [QUO_W-1:0]            r_quo;
    // voltage and curve
    logic [bcg_pkg::SMP_W-1:0]   r_avg;
    logic [bcg_pkg::PROD_W-1:0]  r_prod;
    logic [MV_W-1:0]             r_mv;
    logic [SEG_W-1:0]            r_seg;
    logic                        r_hi;
    logic                        r_lo;
    logic [PCT_W-1:0]            r_base;
    logic [PCT_W-1:0]            r_pct;
    // smoothing
    logic signed [EPROD_W-1:0]   r_eprod;
    logic [Q8_W-1:0]             r_q8;
    logic                        r_primed;
    // result
    logic [MV_W-1:0]             r_out_mv;
    logic [PCT_W-1:0]            r_out_pct;
    logic [bcg_pkg::SMP_W-1:0]   r_out_avg;

    logic [bcg_pkg::SMP_W-1:0]   smp;
    logic [SUM_W-1:0]            sum_next;
    logic [AVG_P_W-1:0]          avg_prod;
    logic [DSH_W-1:0]            rem_ext;
    logic                        div_ge;
    logic [SEG_W-1:0]            seg_c;
    logic [SEG_W-1:0]            seg_lo_idx;
    logic [MV_W-1:0]             lv;
    logic [MV_W-1:0]             span;
    logic [PCT_W-1:0]            dp;
    logic [NUM_W-1:0]            num_full;
    logic [QUO_W:0]              pct_sum;
    logic [bcg_pkg::ALPHA_W-1:0] alpha_sat;
    logic signed [Q8_W:0]        diff;
    logic signed [EPROD_W-1:0]   delta;
    logic signed [EPROD_W-1:0]   q8_sum;
    logic [Q8_W:0]               shown_q8;
    logic [PCT_W:0]              shown;

    assign smp      = i_adc_sample & SMP_MASK;
    assign sum_next = r_sum + SUM_W'(smp);

    // Group average product, latched sum times the reciprocal
    assign avg_prod = AVG_P_W'(r_rem) * AVG_P_W'(AVG_M);

    // Divider step: compare remainder with shifted divisor
    assign rem_ext = DSH_W'(r_rem);
    assign div_ge  = (rem_ext >= r_dsh);

    // Segment search: lowest-numbered segment whose low point is at or below mv
    always_comb begin
        seg_c = '0;
        for (int i = bcg_pkg::SEG_N - 1; i >= 0; i--) begin
            if (r_mv >= bcg_pkg::curve_mv(SEG_W'(i + 1))) begin
                seg_c = SEG_W'(i);
            end
        end
    end

    // Interpolation terms for the chosen segment
    assign seg_lo_idx = r_seg + 1'b1;
    assign lv   = bcg_pkg::curve_mv(seg_lo_idx);
    assign span = bcg_pkg::curve_mv(r_seg) - lv;
    assign dp   = bcg_pkg::curve_pct(r_seg) - bcg_pkg::curve_pct(seg_lo_idx);
    assign num_full = NUM_W'({r_mv - lv, 1'b0}) * NUM_W'(dp) + NUM_W'(span);
    assign pct_sum  = (QUO_W + 1)'(r_base) + (QUO_W + 1)'(r_quo);

    // Smoothing terms
    assign alpha_sat = (r_alpha > bcg_pkg::ALPHA_MAX) ? bcg_pkg::ALPHA_MAX : r_alpha;
    assign diff   = $signed({1'b0, r_pct, 8'b0}) - $signed({1'b0, r_q8});
    assign delta  = (r_eprod + EPROD_W'(128)) >>> 8;
    assign q8_sum = $signed(EPROD_W'(r_q8)) + delta;

    // Displayed percent, rounded half up
    assign shown_q8 = (Q8_W + 1)'(r_q8) + (Q8_W + 1)'(128);
    assign shown    = shown_q8[Q8_W:8];

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain  <= bcg_pkg::GAIN_RST;
            r_alpha <= bcg_pkg::ALPHA_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bcg_pkg::CFG_GAIN:  r_gain  <= i_cfg_data[bcg_pkg::GAIN_W-1:0];
                bcg_pkg::CFG_ALPHA: r_alpha <= i_cfg_data[bcg_pkg::ALPHA_W-1:0];
                default: ;
            endcase
        end
    end

    // Sample sum and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum    <= '0;
            r_q8     <= '0;
            r_primed <= 1'b0;
        end else begin
            if (i_cmd.acc) begin
                r_sum <= i_cmd.grp_end ? '0 : sum_next;
            end
            if (i_cmd.ema_add) begin
                r_primed <= 1'b1;
                if (!r_primed) begin
                    r_q8 <= {r_pct, 8'b0};
                end else if (q8_sum < 0) begin
                    r_q8 <= '0;
                end else if (q8_sum > $signed(EPROD_W'(bcg_pkg::Q8_MAX))) begin
                    r_q8 <= bcg_pkg::Q8_MAX;
                end else begin
                    r_q8 <= q8_sum[Q8_W-1:0];
                end
            end
        end
    end

    // Group average, then the divider for the curve interpolation
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc && i_cmd.grp_end) begin
            r_rem <= sum_next;
        end else if (i_cmd.avg) begin
            r_quo <= avg_prod[AVG_K+QUO_W-1:AVG_K];
        end else if (i_cmd.num) begin
            r_rem <= SUM_W'(num_full);
            r_dsh <= {bcg_pkg::DVS_W'({span, 1'b0}), (QUO_W - 1)'(0)};
            r_quo <= '0;
        end else if (i_cmd.div_step) begin
            if (div_ge) begin
                r_rem <= SUM_W'(rem_ext - r_dsh);
            end
            r_quo <= {r_quo[QUO_W-2:0], div_ge};
            r_dsh <= r_dsh >> 1;
        end
    end

    // Voltage, curve and smoothing pipeline steps
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_avg  <= r_quo;
            r_prod <= bcg_pkg::PROD_W'(r_quo) * bcg_pkg::PROD_W'(r_gain);
        end
        if (i_cmd.mv) begin
            r_mv <= r_prod[bcg_pkg::PROD_W-1] ? bcg_pkg::MV_SAT
                                              : r_prod[bcg_pkg::MV_SHIFT+MV_W-1:bcg_pkg::MV_SHIFT];
        end
        if (i_cmd.seg) begin
            r_seg <= seg_c;
            r_hi  <= (r_mv >= bcg_pkg::curve_mv(SEG_W'(0)));
            r_lo  <= (r_mv <= bcg_pkg::curve_mv(SEG_W'(bcg_pkg::CURVE_N - 1)));
        end
        if (i_cmd.num) begin
            r_base <= bcg_pkg::curve_pct(seg_lo_idx);
        end
        if (i_cmd.pct) begin
            priority if (r_hi) begin
                r_pct <= bcg_pkg::PCT_MAX;
            end else if (r_lo) begin
                r_pct <= '0;
            end else if (pct_sum > (QUO_W + 1)'(bcg_pkg::PCT_MAX)) begin
                r_pct <= bcg_pkg::PCT_MAX;
            end else begin
                r_pct <= pct_sum[PCT_W-1:0];
            end
        end
        if (i_cmd.ema_mul) begin
            r_eprod <= EPROD_W'(diff) * $signed(EPROD_W'(alpha_sat));
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_mv  <= r_mv;
            r_out_avg <= r_avg;
            r_out_pct <= (shown > (PCT_W + 1)'(bcg_pkg::PCT_MAX)) ? bcg_pkg::PCT_MAX
                                                                  : shown[PCT_W-1:0];
        end
    end

    assign o_pack_millivolts = r_out_mv;
    assign o_charge_percent  = r_out_pct;
    assign o_raw_average     = r_out_avg;

endmodule

/* hw/rtl/battery_charge_gauge_top.sv */
// Battery charge gauge top level: joins the controller and the datapath to
// the sample and result channels and the config write port.
// Depends on bcg_pkg, bcg_sample_if, bcg_result_if, bcg_ctrl, bcg_dp.
//
//   channel    dir  handshake            word
//   i_sample   in   valid/ready          adc_sample[11:0]
//   o_result   out  valid/ready          pack_millivolts, charge_percent, raw_average
//   i_cfg_*    in   i_cfg_we, no wait    i_cfg_idx (0 gain, 1 alpha), i_cfg_data[19:0]
//
// Samples inside a group are taken one per cycle. The word that closes a
// group starts the processing (group average by reciprocal multiply,
// gain multiply, curve lookup, a 12-step restoring divide for the
// interpolation, smoothing multiply and add); the result register loads
// after that, and i_sample.ready stays low until it has loaded.
// If the previous result has not been taken, the block holds before loading.
// Synchronous active-low reset clears the sum, count, filter state and result valid flag, and resets the config.
`timescale 1ns / 1ps

module battery_charge_gauge_top #(
    parameter int SAMPLES_PER_READING = bcg_pkg::SAMPLES_DEF,
    parameter int ADC_BITS            = bcg_pkg::ADC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    bcg_sample_if.sink                    i_sample,
    bcg_result_if.source                  o_result,
    input  logic                          i_cfg_we,
    input  logic [bcg_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bcg_pkg::CFG_W-1:0]     i_cfg_data
);

    bcg_pkg::t_cmd cmd;

    bcg_ctrl #(
        .SAMPLES_PER_READING(SAMPLES_PER_READING)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_sample.valid),
        .o_in_ready  (i_sample.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .o_cmd       (cmd)
    );

    bcg_dp #(
        .SAMPLES_PER_READING(SAMPLES_PER_READING),
        .ADC_BITS           (ADC_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_adc_sample      (i_sample.adc_sample),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .o_pack_millivolts (o_result.pack_millivolts),
        .o_charge_percent  (o_result.charge_percent),
        .o_raw_average     (o_result.raw_average)
    );

endmodule

/* hw/rtl/bcg_checker.sv */
// Battery charge gauge port checker and its bind to the top level.
// Watches the result channel and config port only. Depends on bcg_pkg.
`timescale 1ns / 1ps

module bcg_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_res_valid,
    input logic                          i_res_ready,
    input logic [bcg_pkg::MV_W-1:0]      i_res_mv,
    input logic [bcg_pkg::PCT_W-1:0]     i_res_pct,
    input logic [bcg_pkg::SMP_W-1:0]     i_res_avg,
    input logic                          i_cfg_we,
    input logic [bcg_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input logic [bcg_pkg::CFG_W-1:0]     i_cfg_data
);

    logic [bcg_pkg::GAIN_W-1:0] r_gain;
    logic [bcg_pkg::PROD_W-1:0] exp_prod;
    logic [bcg_pkg::MV_W-1:0]   exp_mv;

    // Shadow copy of the gain register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= bcg_pkg::GAIN_RST;
        end else if (i_cfg_we && (i_cfg_idx == bcg_pkg::CFG_GAIN)) begin
            r_gain <= i_cfg_data[bcg_pkg::GAIN_W-1:0];
        end
    end

    assign exp_prod = bcg_pkg::PROD_W'(i_res_avg) * bcg_pkg::PROD_W'(r_gain);
    assign exp_mv   = exp_prod[bcg_pkg::PROD_W-1] ? bcg_pkg::MV_SAT
                    : exp_prod[bcg_pkg::MV_SHIFT+bcg_pkg::MV_W-1:bcg_pkg::MV_SHIFT];

    // No result is offered right after reset
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_mv)
            && $stable(i_res_pct) && $stable(i_res_avg))
        else $error("stalled result changed");

    // Percent never exceeds full charge
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> i_res_pct <= bcg_pkg::PCT_MAX)
        else $error("charge percent above 100");

    // Millivolts agree with the average and the programmed gain
    a_mv_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> i_res_mv == exp_mv)
        else $error("pack millivolts inconsistent with average and gain");

endmodule

bind battery_charge_gauge_top bcg_checker u_bcg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_result.valid),
    .i_res_ready (o_result.ready),
    .i_res_mv    (o_result.pack_millivolts),
    .i_res_pct   (o_result.charge_percent),
    .i_res_avg   (o_result.raw_average),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_idx   (i_cfg_idx),
    .i_cfg_data  (i_cfg_data)
);
